[rtl/fgr_pkg.sv]
// Shared types and constants for the 5x7 font glyph rasterizer.
`default_nettype none
package fgr_pkg;

  localparam int DISPLAY_WIDTH  = 240;
  localparam int DISPLAY_HEIGHT = 240;
  localparam int MAX_SCALE      = 4;

  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_COUNT = 70;
  localparam int IDX_W       = $clog2(GLYPH_COUNT);
  localparam int MASK_W      = 20;

  typedef logic [GLYPH_COLS-1:0] fgr_row_bits_t;
  typedef fgr_row_bits_t [GLYPH_ROWS-1:0] fgr_glyph_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [9:0]  x_pos;
    logic [7:0]  y_pos;
    logic [2:0]  scale;
    logic [15:0] color;
  } fgr_in_t;

  typedef struct packed {
    logic [7:0]        row_y;
    logic [9:0]        start_x;
    logic [MASK_W-1:0] pixel_mask;
    logic [15:0]       pixel_color;
    logic              last_row;
  } fgr_out_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } fgr_rom_req_t;

endpackage
`default_nettype wire

[rtl/font_glyph_rasterizer.sv]
// Top level: 5x7 font glyph rasterizer emitting one pixel row per cycle.
//
// A character is taken when start is high and busy is low. Its glyph is read
// from a synchronous ROM in the cycle after the transfer, and one row leaves
// per clock on out_valid, the first row passing through active_r and then the
// output registers. A glyph makes up to 7*scale rows (28 at the largest scale),
// minus rows below the display; the single row generator sets the rate at one
// row per cycle, and busy drops in the cycle before the final row is on the
// ports, so the next character follows without a gap. A character with an
// unknown code, a scale of zero or a top row below the display is taken
// without raising busy and makes no rows. The receiver cannot stall: every
// row is valid for exactly one cycle.
`default_nettype none
module font_glyph_rasterizer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire fgr_pkg::fgr_in_t in_data,
  output logic                  out_valid,
  output fgr_pkg::fgr_out_t     out_data
);
  import fgr_pkg::*;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } glyph_sel_t;

  function automatic glyph_sel_t glyph_index(input logic [7:0] code);
    glyph_sel_t sel;
    sel.valid = 1'b1;
    sel.idx   = '0;
    case (code) inside
      ["A":"Z"]: sel.idx = IDX_W'(code - "A");
      ["a":"z"]: sel.idx = IDX_W'(code - "a" + 8'd26);
      ["0":"9"]: sel.idx = IDX_W'(code - "0" + 8'd52);
      " ":       sel.idx = IDX_W'(62);
      ".":       sel.idx = IDX_W'(63);
      "-":       sel.idx = IDX_W'(64);
      ":":       sel.idx = IDX_W'(65);
      "@":       sel.idx = IDX_W'(66);
      "<":       sel.idx = IDX_W'(67);
      ">":       sel.idx = IDX_W'(68);
      "+":       sel.idx = IDX_W'(69);
      default:   sel.valid = 1'b0;
    endcase
    return sel;
  endfunction

  // font column c covers mask bits c*s .. c*s+s-1; row bit 4 is column 0
  function automatic logic [MASK_W-1:0] widen(input fgr_row_bits_t bits,
                                              input logic [2:0] s);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      case (s)
        3'd1: m[c] = bits[GLYPH_COLS-1-c];
        3'd2: m[2*c +: 2] = {2{bits[GLYPH_COLS-1-c]}};
        3'd3: m[3*c +: 3] = {3{bits[GLYPH_COLS-1-c]}};
        3'd4: m[4*c +: 4] = {4{bits[GLYPH_COLS-1-c]}};
        default: m = '0;
      endcase
    end
    return m;
  endfunction

  glyph_sel_t        sel;
  logic [2:0]        s_sat;
  logic [4:0]        span;
  logic [8:0]        y_end;
  logic [8:0]        y_last;
  logic [10:0]       room;
  logic [MASK_W-1:0] vis;
  logic              go;
  logic              accept;
  logic              last_cyc;
  fgr_rom_req_t      rom_req;
  fgr_glyph_t        glyph;

  logic              active_r, active_nxt;
  logic [2:0]        row_r, row_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [8:0]        ry_r, ry_nxt;
  logic [8:0]        ylast_r;
  logic [2:0]        s_r;
  logic [9:0]        x_r;
  logic [15:0]       color_r;
  logic [MASK_W-1:0] vis_r;
  logic              out_valid_r;
  fgr_out_t          out_data_r;

  assign sel   = glyph_index(in_data.char_code);
  assign s_sat = (in_data.scale > 3'(MAX_SCALE)) ? 3'(MAX_SCALE) : in_data.scale;
  assign span  = 5'(s_sat) * 5'(GLYPH_ROWS);
  assign y_end = {1'b0, in_data.y_pos} + {4'b0, span} - 9'd1;
  assign y_last = (y_end < 9'(DISPLAY_HEIGHT - 1)) ? y_end : 9'(DISPLAY_HEIGHT - 1);
  assign go = sel.valid && (in_data.scale != 3'd0) &&
              ({1'b0, in_data.y_pos} < 9'(DISPLAY_HEIGHT));

  assign room = 11'(DISPLAY_WIDTH) - {1'b0, in_data.x_pos};
  always_comb begin
    if ({1'b0, in_data.x_pos} >= 11'(DISPLAY_WIDTH)) begin
      vis = '0;
    end else if (room >= 11'(MASK_W)) begin
      vis = '1;
    end else begin
      vis = (MASK_W'(1) << room[4:0]) - MASK_W'(1);
    end
  end

  assign last_cyc = (ry_r == ylast_r);
  assign busy     = active_r && !last_cyc;
  assign accept   = start && !busy;

  assign rom_req.en  = accept && go;
  assign rom_req.idx = sel.idx;

  fgr_glyph_rom u_rom (
    .clk   (clk),
    .req   (rom_req),
    .glyph (glyph)
  );

  always_comb begin
    active_nxt = active_r;
    row_nxt    = row_r;
    k_nxt      = k_r;
    ry_nxt     = ry_r;
    if (accept && go) begin
      active_nxt = 1'b1;
      row_nxt    = '0;
      k_nxt      = '0;
      ry_nxt     = {1'b0, in_data.y_pos};
    end else if (active_r) begin
      if (last_cyc) begin
        active_nxt = 1'b0;
      end else begin
        ry_nxt = ry_r + 9'd1;
        if (({1'b0, k_r} + 3'd1) == s_r) begin
          k_nxt   = '0;
          row_nxt = row_r + 3'd1;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    k_r   <= k_nxt;
    ry_r  <= ry_nxt;
    if (accept && go) begin
      ylast_r <= y_last;
      s_r     <= s_sat;
      x_r     <= in_data.x_pos;
      color_r <= in_data.color;
      vis_r   <= vis;
    end
    if (active_r) begin
      out_data_r.row_y       <= ry_r[7:0];
      out_data_r.start_x     <= x_r;
      out_data_r.pixel_mask  <= widen(glyph[row_r], s_r) & vis_r;
      out_data_r.pixel_color <= color_r;
      out_data_r.last_row    <= last_cyc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_row_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.row_y} < 9'(DISPLAY_HEIGHT)))
    else $error("row below display emitted");

  a_busy_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> active_r)
    else $error("busy without an active glyph");

  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_row |=> out_valid)
    else $error("gap before final row");

  a_rows_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_row |=>
      (out_data.row_y == 8'($past(out_data.row_y) + 8'd1)))
    else $error("row sequence broken");

  a_active_continues: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && !last_cyc |=> active_r)
    else $error("glyph dropped before final row");

endmodule
`default_nettype wire

[rtl/fgr_glyph_rom.sv]
// Synchronous 5x7 glyph ROM with a registered read output.
`default_nettype none
module fgr_glyph_rom (
  input  wire logic                 clk,
  input  wire fgr_pkg::fgr_rom_req_t req,
  output fgr_pkg::fgr_glyph_t        glyph
);
  import fgr_pkg::*;

  localparam logic [GLYPH_COLS-1:0] FontRom [GLYPH_COUNT][GLYPH_ROWS] = '{
    // A..Z
    '{5'd14,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17}, '{5'd30,5'd17,5'd17,5'd30,5'd17,5'd17,5'd30},
    '{5'd15,5'd16,5'd16,5'd16,5'd16,5'd16,5'd15}, '{5'd30,5'd17,5'd17,5'd17,5'd17,5'd17,5'd30},
    '{5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31}, '{5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16},
    '{5'd14,5'd17,5'd16,5'd23,5'd17,5'd17,5'd14}, '{5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17},
    '{5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd31},      '{5'd7,5'd2,5'd2,5'd2,5'd18,5'd18,5'd12},
    '{5'd17,5'd18,5'd20,5'd24,5'd20,5'd18,5'd17}, '{5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31},
    '{5'd17,5'd27,5'd21,5'd21,5'd17,5'd17,5'd17}, '{5'd17,5'd25,5'd21,5'd19,5'd17,5'd17,5'd17},
    '{5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14}, '{5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16},
    '{5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13}, '{5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17},
    '{5'd15,5'd16,5'd16,5'd14,5'd1,5'd1,5'd30},   '{5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4},
    '{5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14}, '{5'd17,5'd17,5'd17,5'd17,5'd17,5'd10,5'd4},
    '{5'd17,5'd17,5'd17,5'd21,5'd21,5'd21,5'd10}, '{5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17},
    '{5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4},     '{5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31},
    // a..z
    '{5'd0,5'd14,5'd1,5'd15,5'd17,5'd19,5'd13},   '{5'd16,5'd16,5'd30,5'd17,5'd17,5'd17,5'd30},
    '{5'd0,5'd14,5'd17,5'd16,5'd16,5'd17,5'd14},  '{5'd1,5'd1,5'd15,5'd17,5'd17,5'd17,5'd15},
    '{5'd0,5'd14,5'd17,5'd31,5'd16,5'd16,5'd14},  '{5'd6,5'd9,5'd8,5'd28,5'd8,5'd8,5'd8},
    '{5'd0,5'd15,5'd17,5'd17,5'd15,5'd1,5'd14},   '{5'd16,5'd16,5'd30,5'd17,5'd17,5'd17,5'd17},
    '{5'd4,5'd0,5'd12,5'd4,5'd4,5'd4,5'd14},      '{5'd2,5'd0,5'd6,5'd2,5'd2,5'd18,5'd12},
    '{5'd16,5'd16,5'd18,5'd20,5'd24,5'd20,5'd18}, '{5'd12,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14},
    '{5'd0,5'd0,5'd26,5'd21,5'd21,5'd21,5'd21},   '{5'd0,5'd0,5'd30,5'd17,5'd17,5'd17,5'd17},
    '{5'd0,5'd14,5'd17,5'd17,5'd17,5'd17,5'd14},  '{5'd0,5'd30,5'd17,5'd17,5'd30,5'd16,5'd16},
    '{5'd0,5'd15,5'd17,5'd17,5'd15,5'd1,5'd1},    '{5'd0,5'd0,5'd22,5'd25,5'd16,5'd16,5'd16},
    '{5'd0,5'd15,5'd16,5'd14,5'd1,5'd1,5'd30},    '{5'd8,5'd8,5'd28,5'd8,5'd8,5'd9,5'd6},
    '{5'd0,5'd0,5'd17,5'd17,5'd17,5'd19,5'd13},   '{5'd0,5'd0,5'd17,5'd17,5'd17,5'd10,5'd4},
    '{5'd0,5'd0,5'd17,5'd17,5'd21,5'd21,5'd10},   '{5'd0,5'd0,5'd17,5'd10,5'd4,5'd10,5'd17},
    '{5'd0,5'd17,5'd17,5'd17,5'd15,5'd1,5'd14},   '{5'd0,5'd0,5'd31,5'd2,5'd4,5'd8,5'd31},
    // 0..9
    '{5'd14,5'd17,5'd19,5'd21,5'd25,5'd17,5'd14}, '{5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14},
    '{5'd14,5'd17,5'd1,5'd2,5'd4,5'd8,5'd31},     '{5'd30,5'd1,5'd1,5'd14,5'd1,5'd1,5'd30},
    '{5'd2,5'd6,5'd10,5'd18,5'd31,5'd2,5'd2},     '{5'd31,5'd16,5'd16,5'd30,5'd1,5'd1,5'd30},
    '{5'd14,5'd16,5'd16,5'd30,5'd17,5'd17,5'd14}, '{5'd31,5'd1,5'd2,5'd4,5'd8,5'd8,5'd8},
    '{5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14}, '{5'd14,5'd17,5'd17,5'd15,5'd1,5'd1,5'd14},
    // space . - : @ < > +
    '{5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0},        '{5'd0,5'd0,5'd0,5'd0,5'd0,5'd12,5'd12},
    '{5'd0,5'd0,5'd0,5'd31,5'd0,5'd0,5'd0},       '{5'd0,5'd12,5'd12,5'd0,5'd12,5'd12,5'd0},
    '{5'd14,5'd17,5'd23,5'd21,5'd23,5'd16,5'd14}, '{5'd2,5'd4,5'd8,5'd16,5'd8,5'd4,5'd2},
    '{5'd8,5'd4,5'd2,5'd1,5'd2,5'd4,5'd8},        '{5'd0,5'd4,5'd4,5'd31,5'd4,5'd4,5'd0}
  };

  always_ff @(posedge clk) begin
    if (req.en) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        glyph[r] <= FontRom[req.idx][r];
      end
    end
  end

endmodule
`default_nettype wire

[sim/font_glyph_rasterizer_tb.sv]
// Self-checking testbench for the 5x7 font glyph rasterizer: directed and random characters.
`timescale 1ns / 1ps
module font_glyph_rasterizer_tb;
  import fgr_pkg::*;

  typedef struct {
    fgr_in_t item;
    int      rows;  // typed row count, -1 when left to the predictor
  } char_case_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  fgr_in_t  in_data;
  logic     out_valid;
  fgr_out_t out_data;

  fgr_out_t   expected_rows[$];
  char_case_t directed[$];

  int fail_count;
  int chars_sent;
  int empty_chars;
  int rows_checked;

  font_glyph_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit lookup_glyph(input logic [7:0] code, output logic [34:0] g);
    lookup_glyph = 1'b1;
    g = '0;
    case (code)
      "A": g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "B": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      "C": g = {5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd15};
      "D": g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      "E": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      "F": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      "G": g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
      "H": g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "I": g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31};
      "J": g = {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
      "K": g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      "L": g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      "M": g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      "N": g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      "O": g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "P": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      "Q": g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      "R": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      "S": g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      "T": g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      "U": g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "V": g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      "W": g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      "X": g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      "Y": g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      "Z": g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      "a": g = {5'd0,  5'd14, 5'd1,  5'd15, 5'd17, 5'd19, 5'd13};
      "b": g = {5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd17, 5'd30};
      "c": g = {5'd0,  5'd14, 5'd17, 5'd16, 5'd16, 5'd17, 5'd14};
      "d": g = {5'd1,  5'd1,  5'd15, 5'd17, 5'd17, 5'd17, 5'd15};
      "e": g = {5'd0,  5'd14, 5'd17, 5'd31, 5'd16, 5'd16, 5'd14};
      "f": g = {5'd6,  5'd9,  5'd8,  5'd28, 5'd8,  5'd8,  5'd8};
      "g": g = {5'd0,  5'd15, 5'd17, 5'd17, 5'd15, 5'd1,  5'd14};
      "h": g = {5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd17, 5'd17};
      "i": g = {5'd4,  5'd0,  5'd12, 5'd4,  5'd4,  5'd4,  5'd14};
      "j": g = {5'd2,  5'd0,  5'd6,  5'd2,  5'd2,  5'd18, 5'd12};
      "k": g = {5'd16, 5'd16, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18};
      "l": g = {5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      "m": g = {5'd0,  5'd0,  5'd26, 5'd21, 5'd21, 5'd21, 5'd21};
      "n": g = {5'd0,  5'd0,  5'd30, 5'd17, 5'd17, 5'd17, 5'd17};
      "o": g = {5'd0,  5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "p": g = {5'd0,  5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16};
      "q": g = {5'd0,  5'd15, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1};
      "r": g = {5'd0,  5'd0,  5'd22, 5'd25, 5'd16, 5'd16, 5'd16};
      "s": g = {5'd0,  5'd15, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      "t": g = {5'd8,  5'd8,  5'd28, 5'd8,  5'd8,  5'd9,  5'd6};
      "u": g = {5'd0,  5'd0,  5'd17, 5'd17, 5'd17, 5'd19, 5'd13};
      "v": g = {5'd0,  5'd0,  5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      "w": g = {5'd0,  5'd0,  5'd17, 5'd17, 5'd21, 5'd21, 5'd10};
      "x": g = {5'd0,  5'd0,  5'd17, 5'd10, 5'd4,  5'd10, 5'd17};
      "y": g = {5'd0,  5'd17, 5'd17, 5'd17, 5'd15, 5'd1,  5'd14};
      "z": g = {5'd0,  5'd0,  5'd31, 5'd2,  5'd4,  5'd8,  5'd31};
      "0": g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      "1": g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      "2": g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      "3": g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      "4": g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      "5": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      "6": g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      "7": g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      "8": g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      "9": g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      " ": g = '0;
      ".": g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      "-": g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      ":": g = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
      "@": g = {5'd14, 5'd17, 5'd23, 5'd21, 5'd23, 5'd16, 5'd14};
      "<": g = {5'd2,  5'd4,  5'd8,  5'd16, 5'd8,  5'd4,  5'd2};
      ">": g = {5'd8,  5'd4,  5'd2,  5'd1,  5'd2,  5'd4,  5'd8};
      "+": g = {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0};
      default: lookup_glyph = 1'b0;
    endcase
  endfunction

  // Queues the rows a character should produce; returns how many.
  function automatic int predict_rows(input fgr_in_t item);
    logic [34:0]      g;
    logic [4:0]       bits;
    logic [19:0]      visible;
    logic [19:0]      mask;
    fgr_out_t         row;
    fgr_out_t         rows[$];
    int               s;
    int               room;
    int               ry;
    if (!lookup_glyph(item.char_code, g) || item.scale == 3'd0) return 0;
    s = (int'(item.scale) > MAX_SCALE) ? MAX_SCALE : int'(item.scale);
    if (int'(item.x_pos) >= DISPLAY_WIDTH) begin
      visible = '0;
    end else begin
      room = DISPLAY_WIDTH - int'(item.x_pos);
      visible = (room >= 20) ? 20'hFFFFF : ((20'h1 << room) - 20'h1);
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      bits = g[34 - 5*r -: 5];
      mask = '0;
      for (int c = 0; c < GLYPH_COLS; c++) begin
        if (bits[4 - c]) begin
          for (int k = 0; k < s; k++) mask[c*s + k] = 1'b1;
        end
      end
      mask &= visible;
      for (int k = 0; k < s; k++) begin
        ry = int'(item.y_pos) + r*s + k;
        if (ry < DISPLAY_HEIGHT) begin
          row.row_y       = ry[7:0];
          row.start_x     = item.x_pos;
          row.pixel_mask  = mask;
          row.pixel_color = item.color;
          row.last_row    = 1'b0;
          rows.push_back(row);
        end
      end
    end
    for (int i = 0; i < rows.size(); i++) begin
      row = rows[i];
      row.last_row = (i == rows.size() - 1);
      expected_rows.push_back(row);
    end
    return rows.size();
  endfunction

  function automatic logic [7:0] glyph_code(input int i);
    if (i < 26) return 8'("A" + i);
    if (i < 52) return 8'("a" + i - 26);
    if (i < 62) return 8'("0" + i - 52);
    case (i)
      62: return " ";
      63: return ".";
      64: return "-";
      65: return ":";
      66: return "@";
      67: return "<";
      68: return ">";
      default: return "+";
    endcase
  endfunction

  function automatic fgr_in_t make_char(input logic [7:0] code, input int x, input int y,
                                        input int s, input int color);
    fgr_in_t item;
    item.char_code = code;
    item.x_pos     = x[9:0];
    item.y_pos     = y[7:0];
    item.scale     = s[2:0];
    item.color     = color[15:0];
    return item;
  endfunction

  task automatic add_case(input logic [7:0] code, input int x, input int y, input int s,
                          input int color, input int rows);
    char_case_t cc;
    cc.item = make_char(code, x, y, s, color);
    cc.rows = rows;
    directed.push_back(cc);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_char(input fgr_in_t item, input int gap, input int typed_rows);
    int n;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    n = predict_rows(item);
    chars_sent++;
    if (n == 0) empty_chars++;
    if (typed_rows >= 0 && n != typed_rows)
      note_failure($sformatf("code %h scale %0d: table says %0d rows, prediction %0d",
                             item.char_code, item.scale, typed_rows, n));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    fgr_out_t want;
    if (rst_n && out_valid) begin
      if (expected_rows.size() == 0) begin
        note_failure($sformatf("unexpected row y=%0d x=%0d mask=%h color=%h last=%b",
                               out_data.row_y, out_data.start_x, out_data.pixel_mask,
                               out_data.pixel_color, out_data.last_row));
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (out_data.row_y !== want.row_y || out_data.start_x !== want.start_x ||
            out_data.pixel_mask !== want.pixel_mask ||
            out_data.pixel_color !== want.pixel_color ||
            out_data.last_row !== want.last_row)
          note_failure($sformatf(
            "row mismatch: exp y=%0d x=%0d mask=%h color=%h last=%b, got y=%0d x=%0d mask=%h color=%h last=%b",
            want.row_y, want.start_x, want.pixel_mask, want.pixel_color, want.last_row,
            out_data.row_y, out_data.start_x, out_data.pixel_mask, out_data.pixel_color,
            out_data.last_row));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d rows outstanding", expected_rows.size());
    $display("** font_glyph_rasterizer: FAILED **");
    $finish;
  end

  initial begin
    fgr_in_t item;
    int      code;
    int      s;
    int      x;
    int      y;
    int      gap;
    bit      burst;
    fail_count   = 0;
    chars_sent   = 0;
    empty_chars  = 0;
    rows_checked = 0;
    burst        = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;

    add_case("A",     0,   0, 1, 16'h0000, 7);
    add_case("A",     0,   0, 0, 16'h1234, 0);   // zero scale
    add_case(8'h00,   0,   0, 1, 16'h5555, 0);   // no glyph
    add_case(8'hFF, 100, 100, 4, 16'hAAAA, 0);
    add_case("Z",     0,   0, 4, 16'hFFFF, 28);
    add_case("8",    10,  10, 7, 16'h8001, 28);  // scale clamps to max
    add_case("W",    30, 100, 5, 16'h7FFE, 28);
    add_case(" ",    50,  50, 2, 16'hF800, 14);  // blank glyph
    add_case(".",     5,   5, 1, 16'h07E0, 7);
    add_case("@",  1023,   0, 2, 16'h001F, 14);  // entirely right of the display
    add_case("M",   239,  20, 1, 16'hFFFF, 7);
    add_case("H",   225,  30, 3, 16'h0F0F, 21);
    add_case("g",     0, 239, 1, 16'hF0F0, 1);
    add_case("q",     0, 255, 1, 16'h3C3C, 0);   // top row below the display
    add_case("k",    64, 236, 2, 16'hC3C3, 4);
    add_case("0",   128, 233, 1, 16'h0001, 7);
    add_case("-",   220,   0, 4, 16'h8000, 28);
    add_case(":",   221,   0, 4, 16'h4321, 28);
    add_case("<",    10,  10, 2, 16'hBEEF, 14);
    add_case(">",   200, 120, 3, 16'h1357, 21);
    add_case("+",   512,  60, 1, 16'h2468, 7);
    add_case("a",   180, 180, 1, 16'h9ABC, 7);
    add_case("/",     0,   0, 1, 16'hFFFF, 0);
    add_case("{",     0,   0, 3, 16'hFFFF, 0);
    add_case("B",  1023, 255, 7, 16'hFFFF, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_char(directed[i].item, $urandom_range(0, 14), directed[i].rows);

    for (int n = 0; n < 450; n++) begin
      if ($urandom_range(0, 19) == 0) burst = !burst;
      code = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                         : glyph_code($urandom_range(0, 69));
      case ($urandom_range(0, 9))
        0:       s = $urandom_range(0, 7);
        1, 2, 3: s = 1;
        default: s = $urandom_range(1, 4);
      endcase
      x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 239);
      case ($urandom_range(0, 5))
        0:       y = $urandom_range(0, 255);
        1:       y = $urandom_range(200, 255);
        default: y = $urandom_range(0, 239);
      endcase
      item = make_char(code[7:0], x, y, s, $urandom_range(0, 65535));
      gap  = burst ? 0 : $urandom_range(0, 14);
      send_char(item, gap, -1);
    end
    start <= 1'b0;

    while (expected_rows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Drew %0d characters (%0d produced no rows); %0d pixel rows checked.",
             chars_sent, empty_chars, rows_checked);
    $display("Failures: %0d", fail_count);
    if (fail_count == 0) begin
      $display("** font_glyph_rasterizer: PASSED **");
    end else begin
      $display("** font_glyph_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fgr_pkg.sv
rtl/fgr_glyph_rom.sv
rtl/font_glyph_rasterizer.sv
sim/font_glyph_rasterizer_tb.sv
